@@ rtl/core/tlpm_pkg.sv @@
// Shared types, constants and codes for the two-level page map translate core.
`timescale 1ns / 1ps

package tlpm_pkg;

  // Address split: directory index, table index, page offset
  localparam int unsigned DIR_ENTRIES       = 1024;
  localparam int unsigned ENTRIES_PER_TABLE = 1024;
  localparam int unsigned IDX_W             = 10;
  localparam int unsigned OFS_W             = 12;
  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned FLAG_W            = 12;
  localparam int unsigned NUM_TABLES_DEF    = 16;

  localparam logic [ADDR_W-1:0] FRAME_MASK  = 32'hFFFF_F000;
  localparam logic [ADDR_W-1:0] OFFSET_MASK = 32'h0000_0FFF;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_FLAGS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_FLAGS   = 1'b1;

  // Reset values of the flag registers
  localparam logic [FLAG_W-1:0] KERNEL_FLAGS_RST = 12'd3;
  localparam logic [FLAG_W-1:0] USER_FLAGS_RST   = 12'd7;

  // Command codes of an input word
  localparam logic CMD_MAP   = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  // Status codes of a result word
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DIR   = 6'b000100,
    ST_CLEAR = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_READ  = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    RES_MISS     = 2'd0,
    RES_MAP_OK   = 2'd1,
    RES_MAP_FULL = 2'd2,
    RES_XLATE    = 2'd3
  } res_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     capture;     // latch the input word
    logic     dir_rd;      // read directory at the incoming index
    logic     dir_clr_wr;  // zero the directory slot at the sweep count
    logic     tbl_clr_wr;  // zero the table entry at the sweep count
    logic     alloc;       // bind the next free table to the directory slot
    logic     ent_rd;      // read the selected table entry
    logic     ent_wr;      // store the new table entry
    logic     cnt_inc;     // advance the sweep counter
    logic     out_load;    // load the result register
    res_sel_e res_sel;
  } tlpm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_xlate;
    logic dir_valid;
    logic pool_empty;
    logic cnt_last;
    logic out_free;
  } tlpm_sts_t;

endpackage

@@ rtl/core/tlpm_ctrl.sv @@
// Controller state machine: sequences directory clear, lookup, table clear and result.
`timescale 1ns / 1ps

module tlpm_ctrl import tlpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tlpm_sts_t sts_i,
  output tlpm_cmd_t cmd_o
);

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.dir_clr_wr = 1'b1;
        cmd_o.cnt_inc    = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.dir_rd  = 1'b1;
          state_d       = ST_DIR;
        end
      end
      ST_DIR: begin
        if (sts_i.is_xlate) begin
          if (sts_i.dir_valid) begin
            cmd_o.ent_rd = 1'b1;
            state_d      = ST_READ;
          end else if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.res_sel  = RES_MISS;
            state_d        = ST_IDLE;
          end
        end else if (sts_i.dir_valid) begin
          state_d = ST_WRITE;
        end else if (!sts_i.pool_empty) begin
          state_d = ST_CLEAR;
        end else if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.res_sel  = RES_MAP_FULL;
          state_d        = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd_o.tbl_clr_wr = 1'b1;
        cmd_o.cnt_inc    = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.alloc = 1'b1;
          state_d     = ST_WRITE;
        end
      end
      ST_WRITE: begin
        // Rewriting the same entry while the result waits is harmless
        cmd_o.ent_wr = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.res_sel  = RES_MAP_OK;
          state_d        = ST_IDLE;
        end
      end
      ST_READ: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.res_sel  = RES_XLATE;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/tlpm_datapath.sv @@
// Datapath: flag registers, directory and table memories, sweep counter, result register.
`timescale 1ns / 1ps

module tlpm_datapath import tlpm_pkg::*; #(
  parameter int unsigned NUM_TABLES = NUM_TABLES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FLAG_W-1:0]    cfg_data_i,
  input  logic                 cmd_i,
  input  logic [ADDR_W-1:0]    virt_addr_i,
  input  logic [ADDR_W-1:0]    phys_addr_i,
  input  logic                 kernel_only_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 found_o,
  output logic [ADDR_W-1:0]    phys_out_o,
  output logic                 status_o,
  input  tlpm_cmd_t            ctl_i,
  output tlpm_sts_t            sts_o
);

  localparam int unsigned SLOT_W   = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int unsigned FREE_W   = $clog2(NUM_TABLES + 1);
  localparam int unsigned DIR_W    = SLOT_W + 1;
  localparam int unsigned ENT_ADDR_W = SLOT_W + IDX_W;
  localparam int unsigned TBL_DEPTH  = NUM_TABLES * ENTRIES_PER_TABLE;

  logic [FLAG_W-1:0] kflags_q, uflags_q;
  logic              cmd_q, kern_q;
  logic [ADDR_W-1:0] va_q, pa_q;
  logic [IDX_W-1:0]  cnt_q;
  logic [FREE_W-1:0] next_free_q;
  logic [DIR_W-1:0]  dir_q;
  logic [ADDR_W-1:0] ent_q;
  logic              out_valid_q, found_q, status_q;
  logic [ADDR_W-1:0] phys_out_q;

  logic [DIR_W-1:0]  dir_mem [DIR_ENTRIES];
  logic [ADDR_W-1:0] tbl_mem [TBL_DEPTH];

  logic [IDX_W-1:0]      didx, tidx;
  logic [SLOT_W-1:0]     free_slot, cur_slot;
  logic                  dir_we;
  logic [IDX_W-1:0]      dir_waddr;
  logic [DIR_W-1:0]      dir_wdata;
  logic [ENT_ADDR_W-1:0] ent_addr;
  logic [ADDR_W-1:0]     new_entry, ent_wdata, xlate_addr;
  logic [FLAG_W-1:0]     flags;

  assign didx      = va_q[ADDR_W-1 -: IDX_W];
  assign tidx      = va_q[OFS_W +: IDX_W];
  assign free_slot = next_free_q[SLOT_W-1:0];
  assign cur_slot  = dir_q[SLOT_W-1:0];

  // Write flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kflags_q <= KERNEL_FLAGS_RST;
      uflags_q <= USER_FLAGS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KERNEL_FLAGS: kflags_q <= cfg_data_i;
        CFG_USER_FLAGS:   uflags_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latch the input word
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q  <= cmd_i;
      va_q   <= virt_addr_i;
      pa_q   <= phys_addr_i;
      kern_q <= kernel_only_i;
    end
  end

  // Advance sweep counter; it wraps to zero after the last entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.cnt_inc) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Advance the free table pointer on allocation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_free_q <= '0;
    end else if (ctl_i.alloc) begin
      next_free_q <= next_free_q + 1'b1;
    end
  end

  // Directory memory: valid bit and table slot
  assign dir_we    = ctl_i.dir_clr_wr | ctl_i.alloc;
  assign dir_waddr = ctl_i.alloc ? didx : cnt_q;
  assign dir_wdata = ctl_i.alloc ? {1'b1, free_slot} : '0;

  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
  end

  // Registered directory read; an allocation updates it in place
  always_ff @(posedge clk_i) begin
    if (ctl_i.alloc) begin
      dir_q <= {1'b1, free_slot};
    end else if (ctl_i.dir_rd) begin
      dir_q <= dir_mem[virt_addr_i[ADDR_W-1 -: IDX_W]];
    end
  end

  // Table memory: clear sweep or entry store, one read port
  assign flags     = kern_q ? kflags_q : uflags_q;
  assign new_entry = (pa_q & FRAME_MASK) | {{(ADDR_W-FLAG_W){1'b0}}, flags};
  assign ent_addr  = ctl_i.tbl_clr_wr ? {free_slot, cnt_q} : {cur_slot, tidx};
  assign ent_wdata = ctl_i.tbl_clr_wr ? '0 : new_entry;

  always_ff @(posedge clk_i) begin
    if (ctl_i.tbl_clr_wr || ctl_i.ent_wr) begin
      tbl_mem[ent_addr] <= ent_wdata;
    end
    if (ctl_i.ent_rd) begin
      ent_q <= tbl_mem[ent_addr];
    end
  end

  // Frame plus page offset
  assign xlate_addr = (ent_q & FRAME_MASK) | (va_q & OFFSET_MASK);

  // Hold result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      unique case (ctl_i.res_sel)
        RES_MISS: begin
          found_q    <= 1'b0;
          phys_out_q <= '0;
          status_q   <= STATUS_OK;
        end
        RES_MAP_OK: begin
          found_q    <= 1'b1;
          phys_out_q <= '0;
          status_q   <= STATUS_OK;
        end
        RES_MAP_FULL: begin
          found_q    <= 1'b0;
          phys_out_q <= '0;
          status_q   <= STATUS_FULL;
        end
        RES_XLATE: begin
          found_q    <= (ent_q != '0);
          phys_out_q <= (ent_q != '0) ? xlate_addr : '0;
          status_q   <= STATUS_OK;
        end
        default: begin
          found_q    <= 1'b0;
          phys_out_q <= '0;
          status_q   <= STATUS_OK;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign phys_out_o  = phys_out_q;
  assign status_o    = status_q;

  // Status back to the controller
  assign sts_o.is_xlate   = (cmd_q == CMD_XLATE);
  assign sts_o.dir_valid  = dir_q[DIR_W-1];
  assign sts_o.pool_empty = (next_free_q == FREE_W'(NUM_TABLES));
  assign sts_o.cnt_last   = &cnt_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

@@ rtl/core/two_level_page_map_translate_core.sv @@
// A translate hit reads the directory, then the entry, then loads the result; a map into a
// present table reads the directory, then stores the entry and loads the result; a translate
// miss or a map that finds the pool empty loads the result after the directory read. A map that
// allocates a table first clears it, one entry per cycle. One word is in flight at a time.
// Reset: flags return to 3 and 7, every table returns to the pool, and a directory clearing
// pass runs with in_ready_o low; configuration writes are taken in every cycle.
`timescale 1ns / 1ps

module two_level_page_map_translate_core import tlpm_pkg::*; #(
  parameter int unsigned NUM_TABLES = NUM_TABLES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FLAG_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cmd_i,
  input  logic [ADDR_W-1:0]    virt_addr_i,
  input  logic [ADDR_W-1:0]    phys_addr_i,
  input  logic                 kernel_only_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 found_o,
  output logic [ADDR_W-1:0]    phys_out_o,
  output logic                 status_o
);

  tlpm_cmd_t ctl_cmd;
  tlpm_sts_t ctl_sts;

  assign cfg_ready_o = 1'b1;

  tlpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (ctl_sts),
    .cmd_o      (ctl_cmd)
  );

  tlpm_datapath #(
    .NUM_TABLES (NUM_TABLES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd_i),
    .virt_addr_i   (virt_addr_i),
    .phys_addr_i   (phys_addr_i),
    .kernel_only_i (kernel_only_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .phys_out_o    (phys_out_o),
    .status_o      (status_o),
    .ctl_i         (ctl_cmd),
    .sts_o         (ctl_sts)
  );

  // Accepted word closes the input until its result is loaded
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // Result register never overwritten while a word still waits
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.out_load |-> ctl_sts.out_free)
    else $error("result loaded over a waiting word");

  // Table clear and entry store never share the write port
  a_tbl_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_cmd.tbl_clr_wr && ctl_cmd.ent_wr))
    else $error("table write port conflict");

  // Allocation only from a non-empty pool
  a_alloc_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.alloc |-> !ctl_sts.pool_empty)
    else $error("table allocated from an empty pool");

endmodule
